@@ design/bth_pkg.sv @@
`timescale 1ns / 1ps

package bth_pkg;

    localparam int C_MAX_ROWS     = 64;
    localparam int C_MAX_BEAM     = 16;
    localparam int C_PAYLOAD_BITS = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_TRACE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_WIDE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BAD_SLOT = 3'd3;
    localparam logic [2:0] ST_BAD_ROW  = 3'd4;

    localparam logic CFG_ROWS_IN_USE = 1'b0;
    localparam logic CFG_BEAM_IN_USE = 1'b1;

    localparam logic [6:0] RESET_ROWS_IN_USE = 7'd64;
    localparam logic [4:0] RESET_BEAM_IN_USE = 5'd16;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] entry_payload;
        logic [3:0]  entry_parent;
        logic        row_end;
        logic [5:0]  start_row;
        logic [3:0]  start_slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  path_row;
        logic [31:0] path_payload;
        logic [3:0]  path_parent;
        logic        last;
        logic [6:0]  rows_stored;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic single;
        logic rd_start;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_trace;
        logic trace_ok;
        logic out_free;
        logic row_zero;
    } t_dp_status;

endpackage

@@ design/bth_ram.sv @@
`timescale 1ns / 1ps

module bth_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bth_ctrl.sv @@
`timescale 1ns / 1ps

module bth_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bth_pkg::t_dp_status i_status,
    output bth_pkg::t_dp_cmd    o_cmd
);

    import bth_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.is_trace && i_status.trace_ok) begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_EMIT;
                end else if (i_status.out_free) begin
                    o_cmd.single = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                // one row per cycle while the output register drains
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.row_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ design/bth_datapath.sv @@
`timescale 1ns / 1ps

module bth_datapath #(
    parameter int MAX_ROWS     = bth_pkg::C_MAX_ROWS,
    parameter int MAX_BEAM     = bth_pkg::C_MAX_BEAM,
    parameter int PAYLOAD_BITS = bth_pkg::C_PAYLOAD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bth_pkg::t_in_item    i_in_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    input  bth_pkg::t_dp_cmd     i_cmd,
    output bth_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bth_pkg::t_out_item   o_out_item
);

    import bth_pkg::*;

    localparam int  PW        = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int  MW        = PW + 4;
    localparam int  DEPTH     = MAX_ROWS * MAX_BEAM;
    localparam int  AW        = $clog2(DEPTH);
    localparam bit  BEAM_CAP  = (MAX_BEAM < 32);

    logic [6:0]    r_rows_in_use;
    logic [4:0]    r_beam_in_use;
    t_in_item      r_item;
    logic [6:0]    r_row_count;
    logic [6:0]    n_row_count;
    logic [4:0]    r_col;
    logic [4:0]    n_col;
    logic [5:0]    r_row;
    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;

    logic [6:0]    w_eff_rows;
    logic [4:0]    w_eff_beam;
    logic [2:0]    w_status;
    logic          w_ins_ok;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [5:0]    w_rd_row;
    logic [3:0]    w_rd_slot;
    logic [MW-1:0] w_rdata;
    logic [3:0]    w_rd_parent;
    logic [3:0]    w_mod_tab [16];

    // parent slot wraps modulo MAX_BEAM, the maximum beam width, worked out at elaboration
    for (genvar g = 0; g < 16; g++) begin : g_mod
        assign w_mod_tab[g] = 4'(g % MAX_BEAM);
    end

    assign w_eff_rows = (r_rows_in_use < 7'(MAX_ROWS)) ? r_rows_in_use : 7'(MAX_ROWS);
    assign w_eff_beam = (BEAM_CAP && (r_beam_in_use >= 5'(MAX_BEAM))) ?
                        5'(MAX_BEAM) : r_beam_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= RESET_ROWS_IN_USE;
            r_beam_in_use <= RESET_BEAM_IN_USE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS_IN_USE) begin
                r_rows_in_use <= i_cfg_data;
            end else begin
                r_beam_in_use <= i_cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    assign o_status.is_trace = (r_item.action == ACT_TRACE);
    assign o_status.trace_ok = ({1'b0, r_item.start_slot} < w_eff_beam) &&
                               ({1'b0, r_item.start_row} < r_row_count);
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.row_zero = (r_row == 6'd0);

    // single-result actions: insert, clear, trace errors, unused code
    always_comb begin
        n_row_count = r_row_count;
        n_col       = r_col;
        w_status    = ST_OK;
        w_ins_ok    = 1'b0;
        case (r_item.action)
            ACT_INSERT: begin
                if (r_col >= w_eff_beam) begin
                    w_status = ST_TOO_WIDE;
                end else if (r_row_count >= w_eff_rows) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_col    = r_col + 5'd1;
                    if (r_item.row_end) begin
                        n_row_count = r_row_count + 7'd1;
                    end
                end
                if (r_item.row_end) begin
                    n_col = 5'd0;
                end
            end
            ACT_TRACE: begin
                if ({1'b0, r_item.start_slot} >= w_eff_beam) begin
                    w_status = ST_BAD_SLOT;
                end else begin
                    w_status = ST_BAD_ROW;
                end
            end
            ACT_CLEAR: begin
                n_row_count = 7'd0;
                n_col       = 5'd0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= 7'd0;
            r_col       <= 5'd0;
        end else if (i_cmd.single) begin
            r_row_count <= n_row_count;
            r_col       <= n_col;
        end
    end

    assign w_we    = i_cmd.single && w_ins_ok;
    assign w_waddr = AW'(r_row_count) * AW'(MAX_BEAM) + AW'(r_col);

    assign w_rd_parent = w_rdata[3:0];

    // trace walk: start at the requested entry, then the parent one row down
    always_comb begin
        if (i_cmd.rd_start) begin
            w_rd_row  = r_item.start_row;
            w_rd_slot = r_item.start_slot;
        end else begin
            w_rd_row  = r_row - 6'd1;
            w_rd_slot = w_mod_tab[w_rd_parent];
        end
    end

    assign w_re    = i_cmd.rd_start || (i_cmd.emit && (r_row != 6'd0));
    assign w_raddr = AW'(w_rd_row) * AW'(MAX_BEAM) + AW'(w_rd_slot);

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_row <= w_rd_row;
        end
    end

    bth_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_item.entry_payload[PW-1:0], r_item.entry_parent}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_out             = '0;
        n_out.rows_stored = r_row_count;
        if (i_cmd.emit) begin
            n_out.status       = ST_OK;
            n_out.path_row     = r_row;
            n_out.path_payload = 32'(w_rdata[MW-1:4]);
            n_out.path_parent  = w_rd_parent;
            n_out.last         = (r_row == 6'd0);
        end else begin
            n_out.status      = w_status;
            n_out.last        = 1'b1;
            n_out.rows_stored = n_row_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.single || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.single || i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ design/beam_traceback_history_top.sv @@
`timescale 1ns / 1ps
// insert, clear and error items: result registered in the decide state once output is free
// trace of N rows: first row read from the store in the decide state, registered in the emit
// state, then one row per cycle while the output register is not stalled
// the walk is paced by the single read port of the entry store and by output stalls
// next item is accepted once the last result of the current one is in the output register
// sync active-low reset clears counts, output valid and config (rows 64, beam 16)
module beam_traceback_history_top #(
    parameter int MAX_ROWS     = bth_pkg::C_MAX_ROWS,
    parameter int MAX_BEAM     = bth_pkg::C_MAX_BEAM,
    parameter int PAYLOAD_BITS = bth_pkg::C_PAYLOAD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bth_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bth_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    import bth_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    bth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bth_datapath #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_BEAM     (MAX_BEAM),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
